[sv/fmhd_pkg.sv]
package fmhd_pkg;

    // Fixed field widths
    localparam int ID_W    = 4;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int TIMER_W = 20;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Client states
    localparam logic [STAT_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STAT_W-1:0] ST_WAIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RUN  = 2'd2;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   client_id;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic [STAT_W-1:0] status_of_client;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input beat, issue memory reads
        logic exec;   // apply update, load result register
        logic fix;    // clear next link of the client that just queued
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;     // result register can take a new beat
        logic join_behind;  // current lock joins a nonempty queue
    } dp_sts_t;

endpackage

[sv/fmhd_ram.sv]
module fmhd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/fmhd_ctrl.sv]
module fmhd_ctrl
    import fmhd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIX  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing: read cycle, update cycle, optional link fix-up
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = sts.join_behind ? S_FIX : S_IDLE;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/fmhd_dp.sv]
module fmhd_dp
    import fmhd_pkg::*;
#(
    parameter int CLIENTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  req_t               in_data,
    input  logic               cfg_valid,
    input  logic [TIMER_W-1:0] cfg_data,
    output rsp_t               out_data,
    output logic               out_valid,
    input  logic               out_ready,
    input  ctl_cmd_t           cmd,
    output dp_sts_t            sts
);

    localparam int AW = $clog2(CLIENTS);
    localparam int LW = $clog2(CLIENTS + 1);
    localparam int XW = (AW > ID_W) ? AW : ID_W;
    localparam logic [LW-1:0] NIL = LW'(CLIENTS);

    // Captured item
    logic [MODE_W-1:0]  mode_reg;
    logic [ID_W-1:0]    cid_reg;

    // Queue and timer state
    logic [LW-1:0]      head_reg, head_next;
    logic [LW-1:0]      tail_reg, tail_next;
    logic [TIMER_W-1:0] elapsed_reg, elapsed_next;
    logic [TIMER_W-1:0] holdoff_reg;
    logic [CLIENTS-1:0] stat_vld_reg;

    // Result register
    logic               out_valid_reg;
    rsp_t               out_data_reg;
    rsp_t               rsp;

    // Memory ports
    logic [AW-1:0]      rd_addr;
    logic [STAT_W-1:0]  stat_rd;
    logic [LW-1:0]      next_rd, prev_rd;
    logic               stat_we, next_we, prev_we;
    logic [AW-1:0]      stat_wa, next_wa, prev_wa;
    logic [STAT_W-1:0]  stat_wd;
    logic [LW-1:0]      next_wd, prev_wd;

    // Decode of the current item
    logic [XW-1:0]      in_ext, cid_ext;
    logic [AW-1:0]      c_addr;
    logic [LW-1:0]      c_lnk;
    logic               in_range;
    logic [STAT_W-1:0]  st;
    logic               join_behind;

    assign in_ext   = XW'(in_data.client_id);
    assign cid_ext  = XW'(cid_reg);
    assign c_addr   = cid_ext[AW-1:0];
    assign c_lnk    = LW'(cid_reg);
    assign in_range = (32'(cid_reg) < CLIENTS);
    assign rd_addr  = cmd.load ? in_ext[AW-1:0] : c_addr;

    // Status of an entry never written reads as idle
    assign st = (in_range && stat_vld_reg[c_addr]) ? stat_rd : ST_IDLE;

    assign join_behind = in_range && (mode_reg == MODE_LOCK) && (st == ST_IDLE)
                         && (head_reg != NIL);

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.join_behind = join_behind;

    fmhd_ram #(.WIDTH(STAT_W), .DEPTH(CLIENTS)) u_stat_ram
    (
        .clk     (clk),
        .wr_en   (stat_we),
        .wr_addr (stat_wa),
        .wr_data (stat_wd),
        .rd_addr (rd_addr),
        .rd_data (stat_rd)
    );

    fmhd_ram #(.WIDTH(LW), .DEPTH(CLIENTS)) u_next_ram
    (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    fmhd_ram #(.WIDTH(LW), .DEPTH(CLIENTS)) u_prev_ram
    (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_wa),
        .wr_data (prev_wd),
        .rd_addr (rd_addr),
        .rd_data (prev_rd)
    );

    // Queue update, memory writes and result
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        elapsed_next = elapsed_reg;
        stat_we      = 1'b0;
        stat_wa      = c_addr;
        stat_wd      = st;
        next_we      = 1'b0;
        next_wa      = c_addr;
        next_wd      = NIL;
        prev_we      = 1'b0;
        prev_wa      = c_addr;
        prev_wd      = NIL;
        rsp.granted          = 1'b0;
        rsp.status_of_client = in_range ? st : ST_IDLE;

        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_TICK:
                begin
                    if (elapsed_reg != TIMER_MAX)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                MODE_LOCK:
                begin
                    if (in_range)
                    begin
                        unique case (st)
                            ST_IDLE:
                            begin
                                stat_we   = 1'b1;
                                prev_we   = 1'b1;
                                tail_next = c_lnk;
                                if (head_reg == NIL)
                                begin
                                    // empty queue: run at once
                                    stat_wd     = ST_RUN;
                                    next_we     = 1'b1;
                                    head_next   = c_lnk;
                                    rsp.granted = 1'b1;
                                    rsp.status_of_client = ST_RUN;
                                end
                                else
                                begin
                                    // append behind current tail
                                    stat_wd = ST_WAIT;
                                    prev_wd = tail_reg;
                                    next_we = (tail_reg != NIL);
                                    next_wa = tail_reg[AW-1:0];
                                    next_wd = c_lnk;
                                    rsp.status_of_client = ST_WAIT;
                                end
                            end
                            ST_WAIT:
                            begin
                                if ((head_reg == c_lnk) && (elapsed_reg >= holdoff_reg))
                                begin
                                    stat_we     = 1'b1;
                                    stat_wd     = ST_RUN;
                                    rsp.granted = 1'b1;
                                    rsp.status_of_client = ST_RUN;
                                end
                            end
                            default:
                            begin
                                rsp.granted = 1'b1;
                            end
                        endcase
                    end
                end
                MODE_UNLOCK:
                begin
                    if (in_range && (st != ST_IDLE))
                    begin
                        // unlink from any position
                        stat_we = 1'b1;
                        stat_wd = ST_IDLE;
                        next_we = (prev_rd != NIL);
                        next_wa = prev_rd[AW-1:0];
                        next_wd = next_rd;
                        prev_we = (next_rd != NIL);
                        prev_wa = next_rd[AW-1:0];
                        prev_wd = prev_rd;
                        if (tail_reg == c_lnk)
                        begin
                            tail_next = prev_rd;
                        end
                        if (head_reg == c_lnk)
                        begin
                            head_next    = next_rd;
                            elapsed_next = '0;
                        end
                        rsp.status_of_client = ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.fix)
        begin
            // new tail has no successor
            next_we = 1'b1;
            next_wa = c_addr;
            next_wd = NIL;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            tail_reg      <= NIL;
            elapsed_reg   <= TIMER_MAX;
            holdoff_reg   <= '0;
            stat_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            elapsed_reg <= elapsed_next;
            if (cfg_valid)
            begin
                holdoff_reg <= cfg_data;
            end
            if (stat_we)
            begin
                stat_vld_reg[c_addr] <= 1'b1;
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data.mode;
            cid_reg  <= in_data.client_id;
        end
        if (cmd.exec)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/fifo_mutex_with_handoff_delay_unit.sv]
// Channel   Direction  Handshake              Beat
// in        input      in_valid / in_ready    req_t: mode, client_id
// out       output     out_valid / out_ready  rsp_t: granted, status_of_client
// cfg       input      cfg_valid / cfg_ready  holdoff_ticks (20 bits)
//
// Per item: a registered read of the status and link memories, then an update
// that writes them; a lock that queues behind others adds a fix-up state, since
// the single write port of the next-link memory is used twice.
// Reset (async, active low) clears head, tail, per-client valid bits and the
// result valid flag and saturates the timer; no clearing pass is needed.
// A result waiting in the output register does not block the next item; that
// item stalls in its update cycle until the register frees. cfg is always ready.
module fifo_mutex_with_handoff_delay_unit
    import fmhd_pkg::*;
#(
    parameter int CLIENTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TIMER_W-1:0] cfg_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    fmhd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fmhd_dp #(.CLIENTS(CLIENTS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[verif/fifo_mutex_with_handoff_delay_unit_test.sv]
module fifo_mutex_with_handoff_delay_unit_test;
    import fmhd_pkg::*;

    localparam int CLIENTS = 16;
    localparam int LINK_W = 5;
    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(CLIENTS);
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    req_t               in_data;
    logic               out_valid;
    logic               out_ready;
    rsp_t               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TIMER_W-1:0] cfg_data;

    // Predicted lock queue state
    logic [STAT_W-1:0]  client_state [CLIENTS];
    logic [LINK_W-1:0]  next_of [CLIENTS];
    logic [LINK_W-1:0]  prev_of [CLIENTS];
    logic [LINK_W-1:0]  queue_head;
    logic [LINK_W-1:0]  queue_tail;
    logic [TIMER_W-1:0] handoff_timer;
    logic [TIMER_W-1:0] holdoff_setting;

    rsp_t pending_answers [$];
    rsp_t oldest_answer;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int idle_cycles;
    int error_count;
    int requests_sent;
    int answers_seen;
    int delayed_grants;
    int holdoff_writes;
    int input_stall_cycles;

    fifo_mutex_with_handoff_delay_unit #(
        .CLIENTS(CLIENTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predicted queue and return the expected answer
    function automatic rsp_t lock_queue_step(input req_t beat);
        rsp_t              answer;
        logic [ID_W-1:0]   ci;
        logic [LINK_W-1:0] c;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        ci = beat.client_id;
        c = {1'b0, ci};
        answer.granted = 1'b0;
        unique case (beat.mode)
            MODE_TICK:
            begin
                if (handoff_timer != TIMER_MAX)
                    handoff_timer = handoff_timer + 1'b1;
            end
            MODE_LOCK:
            begin
                if (client_state[ci] == ST_IDLE)
                begin
                    next_of[ci] = NO_LINK;
                    if (queue_head == NO_LINK)
                    begin
                        // empty queue: run at once, timer not consulted
                        prev_of[ci] = NO_LINK;
                        client_state[ci] = ST_RUN;
                        queue_head = c;
                        answer.granted = 1'b1;
                    end
                    else
                    begin
                        if (queue_tail != NO_LINK)
                            next_of[queue_tail[ID_W-1:0]] = c;
                        prev_of[ci] = queue_tail;
                        client_state[ci] = ST_WAIT;
                    end
                    queue_tail = c;
                end
                else if (client_state[ci] == ST_WAIT)
                begin
                    if (c == queue_head && handoff_timer >= holdoff_setting)
                    begin
                        client_state[ci] = ST_RUN;
                        answer.granted = 1'b1;
                        delayed_grants++;
                    end
                end
                else
                    answer.granted = 1'b1;
            end
            MODE_UNLOCK:
            begin
                if (client_state[ci] != ST_IDLE)
                begin
                    p = prev_of[ci];
                    n = next_of[ci];
                    if (p != NO_LINK)
                        next_of[p[ID_W-1:0]] = n;
                    if (n != NO_LINK)
                        prev_of[n[ID_W-1:0]] = p;
                    if (c == queue_tail)
                        queue_tail = p;
                    // head leaving restarts the hand-off timer
                    if (c == queue_head)
                    begin
                        queue_head = n;
                        handoff_timer = '0;
                    end
                    next_of[ci] = NO_LINK;
                    prev_of[ci] = NO_LINK;
                    client_state[ci] = ST_IDLE;
                end
            end
            default: ;
        endcase
        answer.status_of_client = client_state[ci];
        return answer;
    endfunction

    // Offer one request beat; predict its answer once accepted
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        req_t beat;
        beat.mode = mode;
        beat.client_id = id;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_answers.push_back(lock_queue_step(beat));
        requests_sent++;
    endtask

    // Stop offering, wait for every answer, then let the pipeline settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_holdoff(input logic [TIMER_W-1:0] ticks);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        holdoff_setting = ticks;
        holdoff_writes++;
    endtask

    // Saturated timer, unused mode, idle unlock, queue joins and removals
    task automatic test_queue_basics();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(MODE_TICK, 4'd15);
        send_request(MODE_NONE, 4'd0);
        send_request(MODE_UNLOCK, 4'd3);
        send_request(MODE_LOCK, 4'd0);
        send_request(MODE_LOCK, 4'd0);
        send_request(MODE_LOCK, 4'd15);
        send_request(MODE_LOCK, 4'd5);
        send_request(MODE_LOCK, 4'd5);
        send_request(MODE_UNLOCK, 4'd15);
        send_request(MODE_UNLOCK, 4'd0);
    endtask

    // New head waits out the delay; empty queue ignores the timer
    task automatic test_handoff_delay();
        write_holdoff(20'd2);
        send_request(MODE_LOCK, 4'd5);
        send_request(MODE_TICK, 4'd9);
        send_request(MODE_LOCK, 4'd5);
        send_request(MODE_TICK, 4'd6);
        send_request(MODE_LOCK, 4'd5);
        send_request(MODE_UNLOCK, 4'd5);
        send_request(MODE_LOCK, 4'd10);
        send_request(MODE_NONE, 4'd10);
        send_request(MODE_UNLOCK, 4'd10);
    endtask

    // Largest delay: the next head cannot be granted within the run
    task automatic test_holdoff_max();
        write_holdoff(TIMER_MAX);
        send_request(MODE_LOCK, 4'd1);
        send_request(MODE_LOCK, 4'd2);
        send_request(MODE_UNLOCK, 4'd1);
        send_request(MODE_LOCK, 4'd2);
        send_request(MODE_UNLOCK, 4'd2);
    endtask

    // Mostly well-formed lock traffic, biased toward the head to force hand-offs
    task automatic test_random_traffic(input int count, input int sender_pct,
                                       input int receiver_pct, input logic [TIMER_W-1:0] delay);
        int                pick;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        write_holdoff(delay);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            id = ID_W'($urandom_range(CLIENTS - 1));
            if (pick < 40)
            begin
                mode = MODE_LOCK;
                if (queue_head != NO_LINK && $urandom_range(2) == 0)
                    id = queue_head[ID_W-1:0];
            end
            else if (pick < 65)
            begin
                mode = MODE_UNLOCK;
                if (queue_head != NO_LINK && client_state[queue_head[ID_W-1:0]] == ST_RUN
                    && $urandom_range(1) == 0)
                    id = queue_head[ID_W-1:0];
            end
            else if (pick < 95)
                mode = MODE_TICK;
            else
                mode = MODE_NONE;
            send_request(mode, id);
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        repeat (40)
            send_request(MODE_W'(MODE_LOCK + $urandom_range(2)),
                         ID_W'($urandom_range(CLIENTS - 1)));
    endtask

    // Receiver: random ready, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request != 0)
        begin
            out_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_request = 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Answer checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected answer granted=%0d status=%0d",
                         $time, out_data.granted, out_data.status_of_client);
            end
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (out_data.granted !== oldest_answer.granted)
                begin
                    error_count++;
                    $display("%0t: granted expected %0d actual %0d", $time,
                             oldest_answer.granted, out_data.granted);
                end
                if (out_data.status_of_client !== oldest_answer.status_of_client)
                begin
                    error_count++;
                    $display("%0t: status_of_client expected %0d actual %0d", $time,
                             oldest_answer.status_of_client, out_data.status_of_client);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 0;
        hold_left = 0;
        idle_cycles = 0;
        error_count = 0;
        requests_sent = 0;
        answers_seen = 0;
        delayed_grants = 0;
        holdoff_writes = 0;
        input_stall_cycles = 0;
        for (int i = 0; i < CLIENTS; i++)
        begin
            client_state[i] = ST_IDLE;
            next_of[i] = NO_LINK;
            prev_of[i] = NO_LINK;
        end
        queue_head = NO_LINK;
        queue_tail = NO_LINK;
        handoff_timer = TIMER_MAX;
        holdoff_setting = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_queue_basics();
        test_handoff_delay();
        test_holdoff_max();
        test_random_traffic(470, 23, 85, 20'd0);
        test_random_traffic(470, 85, 23, 20'($urandom_range(1, 4)));
        test_random_traffic(470, 0, 0, 20'($urandom_range(2, 8)));
        test_output_backpressure();
        wait_quiet();

        $display("Run covered %0d requests and %0d answers over %0d holdoff settings,",
                 requests_sent, answers_seen, holdoff_writes);
        $display("with %0d grants after a hand-off delay and %0d input stall cycles.",
                 delayed_grants, input_stall_cycles);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[fifo_mutex_with_handoff_delay_unit.f]
sv/fmhd_pkg.sv
sv/fmhd_ram.sv
sv/fmhd_ctrl.sv
sv/fmhd_dp.sv
sv/fifo_mutex_with_handoff_delay_unit.sv
verif/fifo_mutex_with_handoff_delay_unit_test.sv
